// File: rtl/dpp_pkg.sv
// Package for the dependency file prerequisite parser.
// Holds character codes, parser state and result types, and the per-character
// decision functions used by dpp_parse. No dependencies.
package dpp_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int unsigned MAX_RES   = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW   = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_valid;
    logic       past_target;
    logic       token_open;
    logic       token_ends_colon;
    logic       rule_finished;
  } st_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       dep_end;
    logic       list_end;
  } res_t;

  // Results of one item, handed from the parser to the result queue.
  typedef struct packed {
    logic [1:0]       n;
    res_t [1:0]       res;
  } push_t;

  typedef struct packed {
    st_t        st;
    res_t [1:0] res;
    logic [1:0] n;
    logic       skip;
  } work_t;

  localparam res_t RES_ZERO = '{has_byte: 1'b0, out_byte: 8'h00, dep_end: 1'b0,
                                list_end: 1'b0};
  localparam st_t ST_RESET = '{held_byte: 8'h00, held_valid: 1'b0, past_target: 1'b0,
                               token_open: 1'b0, token_ends_colon: 1'b0,
                               rule_finished: 1'b0};

  // Slot of the last result written; only meaningful when n is nonzero.
  function automatic logic prev_idx(logic [1:0] n);
    return (n == 2'd2);
  endfunction

  function automatic work_t put_byte(work_t w_in, logic [7:0] c);
    work_t w;
    logic  idx;
    w = w_in;
    idx = (w.n != 2'd0);
    w.res[idx] = '{has_byte: 1'b1, out_byte: c, dep_end: 1'b0, list_end: 1'b0};
    w.n = {1'b0, idx} + 2'd1;
    return w;
  endfunction

  function automatic work_t put_dep_end(work_t w_in);
    work_t w;
    logic  pi;
    w = w_in;
    pi = prev_idx(w.n);
    if (w.n != 2'd0 && (w.n == 2'd2 ||
        (w.res[pi].has_byte && !w.res[pi].dep_end))) begin
      w.res[pi].dep_end = 1'b1;
    end else begin
      w.res[w.n[0]] = '{has_byte: 1'b0, out_byte: 8'h00, dep_end: 1'b1, list_end: 1'b0};
      w.n = w.n + 2'd1;
    end
    return w;
  endfunction

  function automatic work_t put_list_end(work_t w_in);
    work_t w;
    w = w_in;
    if (w.n != 2'd0) begin
      w.res[prev_idx(w.n)].list_end = 1'b1;
    end else begin
      w.res[0] = '{has_byte: 1'b0, out_byte: 8'h00, dep_end: 1'b0, list_end: 1'b1};
      w.n = 2'd1;
    end
    return w;
  endfunction

  function automatic work_t append_char(work_t w_in, logic [7:0] c);
    work_t w;
    w = w_in;
    w.st.token_open = 1'b1;
    if (w.st.past_target) begin
      w = put_byte(w, c);
    end else begin
      w.st.token_ends_colon = (c == CH_COLON);
    end
    return w;
  endfunction

  function automatic work_t close_token(work_t w_in);
    work_t w;
    w = w_in;
    if (w.st.token_open) begin
      if (w.st.past_target) begin
        w = put_dep_end(w);
      end else if (w.st.token_ends_colon) begin
        w.st.past_target = 1'b1;
      end
      w.st.token_open = 1'b0;
      w.st.token_ends_colon = 1'b0;
    end
    return w;
  endfunction

  // Decide one character against its one-character lookahead.
  function automatic work_t decide(work_t w_in, logic [7:0] cur, logic [7:0] nxt);
    work_t w;
    w = w_in;
    w.skip = 1'b0;
    if (!w.st.rule_finished) begin
      if (cur == CH_BSL && nxt == CH_NL) begin
        w.skip = 1'b1;
      end else if (cur == CH_BSL && nxt == CH_SP) begin
        w = append_char(w, CH_SP);
        w.skip = 1'b1;
      end else if (cur == CH_NL) begin
        w = close_token(w);
        if (w.st.past_target) begin
          w.st.rule_finished = 1'b1;
        end
      end else if (cur == CH_SP || cur == CH_TAB) begin
        w = close_token(w);
      end else if (cur == CH_COLON && !w.st.past_target &&
                   (nxt == CH_SP || nxt == CH_NL || nxt == CH_BSL)) begin
        w.st.past_target = 1'b1;
        w.st.token_open = 1'b0;
        w.st.token_ends_colon = 1'b0;
      end else begin
        w = append_char(w, cur);
      end
    end
    return w;
  endfunction

endpackage

// File: rtl/dpp_parse.sv
// Parser state and per-item decision logic of the prerequisite parser.
// Depends on dpp_pkg for types and decision functions.
module dpp_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_vld,
  input  logic [7:0]      text_byte,
  input  logic            last_byte,
  output dpp_pkg::push_t  push
);

  dpp_pkg::st_t  st_r;
  dpp_pkg::st_t  st_nxt;
  dpp_pkg::work_t w;

  always_comb begin
    w.st   = st_r;
    w.res  = {dpp_pkg::RES_ZERO, dpp_pkg::RES_ZERO};
    w.n    = 2'd0;
    w.skip = 1'b0;
    if (st_r.held_valid) begin
      w = dpp_pkg::decide(w, st_r.held_byte, text_byte);
      w.st.held_valid = 1'b0;
    end
    // w.skip now says whether the held byte consumed this one
    if (!last_byte) begin
      if (!w.skip) begin
        w.st.held_byte  = text_byte;
        w.st.held_valid = 1'b1;
      end
    end else begin
      if (!w.skip) begin
        w = dpp_pkg::decide(w, text_byte, dpp_pkg::CH_NL);
      end
      if (!w.st.rule_finished) begin
        w = dpp_pkg::close_token(w);
      end
      w = dpp_pkg::put_list_end(w);
      w.st = dpp_pkg::ST_RESET;
    end
    st_nxt = w.st;
    push.n   = w.n;
    push.res = w.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dpp_pkg::ST_RESET;
    end else if (item_vld) begin
      st_r <= st_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && last_byte |=> !st_r.held_valid && !st_r.past_target && !st_r.rule_finished)
    else $error("parser state not cleared after last byte");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && last_byte |-> push.n != 2'd0)
    else $error("last byte produced no list end");

  a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && !last_byte && st_r.rule_finished |-> push.n == 2'd0)
    else $error("results produced after rule finished");

endmodule

// File: rtl/dpp_result_fifo.sv
// Four-entry result queue: takes up to two results per cycle, gives one unless stalled.
// Depends on dpp_pkg for the result types and depth.
module dpp_result_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_vld,
  input  dpp_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output dpp_pkg::res_t  out_res
);

  dpp_pkg::res_t                     mem_r [dpp_pkg::FIFO_DEPTH];
  logic [dpp_pkg::FIFO_AW-1:0]       wr_ptr_r;
  logic [dpp_pkg::FIFO_AW-1:0]       rd_ptr_r;
  logic [dpp_pkg::FIFO_AW:0]         count_r;
  logic [dpp_pkg::FIFO_AW:0]         count_nxt;
  logic [1:0]                        push_n;
  logic                              pop;

  assign push_n    = push_vld ? push.n : 2'd0;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  // Room for a full two-result push regardless of this cycle's pop.
  assign room      = (count_r <= (dpp_pkg::FIFO_AW+1)'(dpp_pkg::FIFO_DEPTH - dpp_pkg::MAX_RES));
  assign out_res   = mem_r[rd_ptr_r];
  assign count_nxt = count_r + (dpp_pkg::FIFO_AW+1)'(push_n)
                     - (dpp_pkg::FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res[0];
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + dpp_pkg::FIFO_AW'(1)] <= push.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + dpp_pkg::FIFO_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + dpp_pkg::FIFO_AW'(pop);
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_vld |-> (count_r + (dpp_pkg::FIFO_AW+1)'(push_n)) <=
                 (dpp_pkg::FIFO_AW+1)'(dpp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_vld |-> room)
    else $error("push without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_nxt))
    else $error("queue count mismatch");

endmodule

// File: rtl/depfile_prerequisite_parser.sv
// Top level of the make-style dependency file prerequisite parser.
// Instantiates dpp_parse and dpp_result_fifo; uses dpp_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) moves one text byte per transfer,
//   with in_last_byte set on the final byte of the text. Output channel
//   (out_valid / out_stall) moves one result per transfer: a prerequisite
//   byte (out_has_byte), a token end marker (out_dep_end) and the list end
//   marker (out_list_end), which rides on the last result of the text.
//   Each input byte yields zero, one or two results.
// Order: a byte enters the input register on its transfer and, when the
//   queue has room, moves into the parser and is held there; it is
//   decided against its successor when that arrives (the last byte at once,
//   against a newline), and its results are queued and offered on the output.
// Throughput: one byte per cycle while results drain as fast as they are
//   made; the output moves one result per cycle while out_stall is low, and
//   a byte is only decided when the queue has room for two results.
// Reset (rst_n low, synchronous) clears the parser state, the input
//   register and the queue. After the last byte the parser state returns
//   to reset by itself.
// When the receiver stalls, queued results hold; once the queue lacks room
//   the input register holds and in_stall rises.
module depfile_prerequisite_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_byte,
  output logic [7:0] out_byte,
  output logic       out_dep_end,
  output logic       out_list_end
);

  logic            stg_vld_r;
  logic            stg_vld_nxt;
  logic [7:0]      stg_byte_r;
  logic            stg_last_r;
  logic            room;
  logic            adv;
  logic            in_xfer;
  dpp_pkg::push_t  push;
  dpp_pkg::res_t   out_res;

  // Advance the input register into the parser when the queue has room.
  assign adv      = stg_vld_r && room;
  assign in_stall = stg_vld_r && !room;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_xfer) begin
      stg_vld_nxt = 1'b1;
    end else if (adv) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  // Payload: load on every input transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_byte_r <= in_text_byte;
      stg_last_r <= in_last_byte;
    end
  end

  dpp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (adv),
    .text_byte (stg_byte_r),
    .last_byte (stg_last_r),
    .push      (push)
  );

  dpp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (adv),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_has_byte = out_res.has_byte;
  assign out_byte     = out_res.out_byte;
  assign out_dep_end  = out_res.dep_end;
  assign out_list_end = out_res.list_end;

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !room |=> stg_vld_r && $stable(stg_byte_r) && $stable(stg_last_r))
    else $error("input register changed while blocked");

  a_xfer_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stg_vld_r)
    else $error("accepted byte lost");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_vld_r |-> !in_stall)
    else $error("stall with empty input register");

endmodule

// File: bench/testbench.sv
// Self-checking bench for depfile_prerequisite_parser: streams dependency
// file texts, predicts the prerequisite byte stream and checks each result.
// Depends on dpp_pkg (character codes, res_t) and the parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET    = 1250;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic       out_has_byte;
  logic [7:0] out_byte;
  logic       out_dep_end;
  logic       out_list_end;

  depfile_prerequisite_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_text_byte(in_text_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_has_byte(out_has_byte),
    .out_byte    (out_byte),
    .out_dep_end (out_dep_end),
    .out_list_end(out_list_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prerequisite predictor: mirrors the parser state and appends the
  // expected result stream for every byte the parser accepts.
  // ---------------------------------------------------------------------
  logic [7:0] held_char   = 8'h00;  // lookahead byte waiting for its successor
  logic       held_ok     = 1'b0;
  logic       skip_next   = 1'b0;   // held byte swallowed the byte after it
  logic       target_seen = 1'b0;   // tokens are now prerequisites
  logic       tok_live    = 1'b0;
  logic       tok_colon   = 1'b0;   // open target token ends in a colon
  logic       rule_done   = 1'b0;   // first rule complete, ignore the rest

  dpp_pkg::res_t dep_batch [0:1];   // results of the byte being predicted
  int            batch_n;
  dpp_pkg::res_t dep_stream [$];    // expected results, oldest first

  function automatic void emit_char(input logic [7:0] c);
    // A third result overwrites the second slot, as the parser does.
    if (batch_n >= 2) batch_n = 1;
    dep_batch[batch_n] = '{has_byte: 1'b1, out_byte: c, dep_end: 1'b0, list_end: 1'b0};
    batch_n++;
  endfunction

  function automatic void emit_dep_end();
    // Fold the marker onto the previous byte when that byte is still open or the batch is full.
    if (batch_n > 0 && (batch_n >= 2 ||
        (dep_batch[batch_n-1].has_byte && !dep_batch[batch_n-1].dep_end))) begin
      dep_batch[batch_n-1].dep_end = 1'b1;
    end else begin
      dep_batch[batch_n] = '{has_byte: 1'b0, out_byte: 8'h00, dep_end: 1'b1,
                             list_end: 1'b0};
      batch_n++;
    end
  endfunction

  function automatic void emit_list_end();
    if (batch_n > 0) begin
      dep_batch[batch_n-1].list_end = 1'b1;
    end else begin
      dep_batch[0] = '{has_byte: 1'b0, out_byte: 8'h00, dep_end: 1'b0, list_end: 1'b1};
      batch_n = 1;
    end
  endfunction

  function automatic void extend_token(input logic [7:0] c);
    tok_live = 1'b1;
    if (target_seen) emit_char(c);
    else tok_colon = (c == dpp_pkg::CH_COLON);
  endfunction

  function automatic void shut_token();
    if (tok_live) begin
      if (target_seen) emit_dep_end();
      else if (tok_colon) target_seen = 1'b1;
      tok_live  = 1'b0;
      tok_colon = 1'b0;
    end
  endfunction

  // Decide one character against the character that follows it.
  function automatic void classify(input logic [7:0] cur, input logic [7:0] nxt);
    skip_next = 1'b0;
    if (!rule_done) begin
      if (cur == dpp_pkg::CH_BSL && nxt == dpp_pkg::CH_NL) begin
        skip_next = 1'b1;
      end else if (cur == dpp_pkg::CH_BSL && nxt == dpp_pkg::CH_SP) begin
        extend_token(dpp_pkg::CH_SP);
        skip_next = 1'b1;
      end else if (cur == dpp_pkg::CH_NL) begin
        shut_token();
        if (target_seen) rule_done = 1'b1;
      end else if (cur == dpp_pkg::CH_SP || cur == dpp_pkg::CH_TAB) begin
        shut_token();
      end else if (cur == dpp_pkg::CH_COLON && !target_seen &&
                   (nxt == dpp_pkg::CH_SP || nxt == dpp_pkg::CH_NL ||
                    nxt == dpp_pkg::CH_BSL)) begin
        target_seen = 1'b1;
        tok_live    = 1'b0;
        tok_colon   = 1'b0;
      end else begin
        extend_token(cur);
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic live;
    live    = 1'b1;
    batch_n = 0;
    if (held_ok) begin
      classify(held_char, b);
      if (skip_next) live = 1'b0;
      skip_next = 1'b0;
      held_ok   = 1'b0;
    end
    if (!fin) begin
      if (live) begin
        held_char = b;
        held_ok   = 1'b1;
      end
    end else begin
      // End of text acts as a newline lookahead, then the state clears.
      if (live) classify(b, dpp_pkg::CH_NL);
      skip_next = 1'b0;
      if (!rule_done) shut_token();
      emit_list_end();
      held_char   = 8'h00;
      held_ok     = 1'b0;
      target_seen = 1'b0;
      tok_live    = 1'b0;
      tok_colon   = 1'b0;
      rule_done   = 1'b0;
    end
    for (int i = 0; i < batch_n; i++) dep_stream = {dep_stream, dep_batch[i]};
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: compare every result transfer with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  int            mismatches = 0;
  dpp_pkg::res_t seen_res;
  dpp_pkg::res_t want_res;

  task automatic report_mismatch(input string what, input dpp_pkg::res_t got,
                                 input dpp_pkg::res_t want);
    mismatches++;
    $display("%0t ns %s: got has=%0b byte=%h dep=%0b list=%0b, %s%0b byte=%h dep=%0b list=%0b",
             $time, what, got.has_byte, got.out_byte, got.dep_end, got.list_end,
             "want has=", want.has_byte, want.out_byte, want.dep_end, want.list_end);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_res = {out_has_byte, out_byte, out_dep_end, out_list_end};
      if (dep_stream.size() == 0) begin
        report_mismatch("result with nothing pending", seen_res, '0);
      end else begin
        want_res = dep_stream.pop_front();
        if (seen_res.has_byte !== want_res.has_byte ||
            seen_res.out_byte !== want_res.out_byte ||
            seen_res.dep_end  !== want_res.dep_end  ||
            seen_res.list_end !== want_res.list_end)
          report_mismatch("result differs", seen_res, want_res);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall in random bursts, none while calm.
  // ---------------------------------------------------------------------
  logic calm = 1'b0;
  int   stall_left = 0;

  always @(negedge clk) begin
    if (calm || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Sender: one transfer per call, with random idle bursts before it.
  // ---------------------------------------------------------------------
  logic [7:0] draft [$];   // text being built for the next send
  int         live_items = 0;

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= ch;
    in_last_byte <= fin;
    // Hold the payload until the input register takes it.
    do @(posedge clk); while (in_stall);
    live_items++;
    parse_byte(ch, fin);
  endtask

  task automatic send_draft();
    for (int i = 0; i < draft.size(); i++) send_char(draft[i], i == draft.size() - 1);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (dep_stream.size() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] c);
    draft = {draft, c};
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // One path character: mostly plain letters, sometimes a slash, escaped space, colon or any byte.
  function automatic void add_path_char();
    case ($urandom_range(0, 9))
      0: add_byte(8'($urandom_range(0, 255)));
      1: begin
        add_byte(dpp_pkg::CH_BSL);
        add_byte(dpp_pkg::CH_SP);
      end
      2: add_byte(dpp_pkg::CH_COLON);
      3: add_str("/");
      default: add_byte(8'($urandom_range(8'h61, 8'h7A)));
    endcase
  endfunction

  // Whitespace between prerequisites, continuations included.
  function automatic void add_separator();
    case ($urandom_range(0, 4))
      0: add_byte(dpp_pkg::CH_SP);
      1: add_byte(dpp_pkg::CH_TAB);
      2: add_str(" \\\n ");
      3: add_str("\\\n");
      default: add_str("  \t");
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 9))
      0: return dpp_pkg::CH_NL;
      1: return dpp_pkg::CH_COLON;
      2: return dpp_pkg::CH_BSL;
      3: return dpp_pkg::CH_SP;
      4: return dpp_pkg::CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build and send one text: mostly a well-formed rule, sometimes noise.
  task automatic send_random_rule();
    draft.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 24)) add_byte(noise_char());
    end else begin
      repeat ($urandom_range(1, 6)) add_path_char();
      case ($urandom_range(0, 5))
        0: add_str(": ");
        1: add_str(":\t");
        2: add_str(":\\\n");
        3: add_str(" : ");
        4: add_str(":\n");
        default: add_str(":");
      endcase
      repeat ($urandom_range(0, 5)) begin
        add_separator();
        repeat ($urandom_range(1, 8)) add_path_char();
      end
      case ($urandom_range(0, 4))
        0: ;
        1: add_str("\n");
        2: begin
          add_str("\n");
          repeat ($urandom_range(1, 6)) add_byte(noise_char());
        end
        3: add_str(" \t");
        default: add_byte(dpp_pkg::CH_BSL);
      endcase
    end
    send_draft();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Short hand-made texts: single byte, colon-ended target token, escaped
  // space, continuation, trailing bytes after the rule, extreme byte values,
  // a text ending in a backslash and a text ending in a colon.
  task automatic test_edge_texts();
    draft.delete();
    add_byte(8'hFF);
    send_draft();
    draft.delete();
    add_str("o:\tx\\ y\\\nz\n!");
    send_draft();
    draft.delete();
    add_str("a: ");
    add_byte(8'h00);
    add_str("b\\");
    send_draft();
    draft.delete();
    add_str("c:");
    send_draft();
  endtask

  // Random rules with idling on both sides.
  task automatic test_random_rules();
    while (live_items < ITEM_TARGET * 7 / 10) send_random_rule();
  endtask

  // Pause the sender until every pending result has drained.
  task automatic test_drain_pause();
    repeat (20) begin
      send_random_rule();
      hold_input();
      drain_results();
    end
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream();
    calm = 1'b1;
    while (live_items < ITEM_TARGET) send_random_rule();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_texts();
    test_random_rules();
    test_drain_pause();
    test_steady_stream();

    // Drop valid, let the queue empty and give stray results time to show.
    hold_input();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && dep_stream.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
